// ===== rtl/bls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg
// Types, codes and constants shared by the battery level supervisor modules.
// ----------------------------------------------------------------------------
package bls_pkg;

  // converter sample width
  localparam int ADC_BITS = 12;
  // width of the offset register
  localparam int OFFSET_BITS = 12;
  // width that holds both a sample and the offset
  localparam int LVL_W = (ADC_BITS > OFFSET_BITS) ? ADC_BITS : OFFSET_BITS;

  // divide by ten: (x * DIV10_MULT) >> DIV10_SHIFT is exact for x below 2**16
  localparam logic [15:0] DIV10_MULT  = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;
  localparam int          PROD_W      = LVL_W + 16;
  localparam int          QUOT_W      = PROD_W - DIV10_SHIFT;

  localparam logic [7:0] PERCENT_MAX = 8'd255;
  localparam logic [3:0] COUNT_MAX   = 4'd15;

  // system modes
  localparam logic [2:0] MODE_RUN      = 3'd1;
  localparam logic [2:0] MODE_LOW      = 3'd2;
  localparam logic [2:0] MODE_DISABLED = 3'd3;

  // battery bands
  localparam logic [1:0] BAND_CRITICAL = 2'd0;
  localparam logic [1:0] BAND_MEDIUM   = 2'd1;
  localparam logic [1:0] BAND_GOOD     = 2'd2;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CHECKING_ENABLE = 3'd0,
    CFG_ADC_OFFSET      = 3'd1,
    CFG_GOOD_LEVEL      = 3'd2,
    CFG_CRITICAL_LEVEL  = 3'd3,
    CFG_CONFIRM_COUNT   = 3'd4
  } cfg_idx_t;

  // configuration register file
  typedef struct packed {
    logic                   checking_enable;
    logic [OFFSET_BITS-1:0] adc_offset;
    logic [7:0]             good_level;
    logic [7:0]             critical_level;
    logic [3:0]             confirm_count;
  } cfg_t;

  // input transaction
  typedef struct packed {
    logic [ADC_BITS-1:0] adc_sample;
    logic                last_sample;
    logic [2:0]          system_mode;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [7:0] battery_percent;
    logic [1:0] battery_band;
    logic [2:0] next_mode;
  } out_item_t;

  // finished burst average handed from front to back
  typedef struct packed {
    logic [ADC_BITS-1:0] average;
    logic [2:0]          mode;
  } meas_t;

  // front to back queue handshake
  typedef struct packed {
    logic  valid;
    meas_t meas;
  } meas_q_t;

endpackage

// ===== rtl/battery_level_supervisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_supervisor
// Averages bursts of battery converter samples and confirms charge bands.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue: an in_item transaction is taken at a clock edge with
//   push high and full low. While checking is enabled, each sample feeds a
//   running halving average and a sample with last_sample set closes the
//   burst and yields one result. Results are a queue: while empty is low the
//   oldest result is on out_item, and pop with empty low takes it.
//   Path: a closing sample's average passes the burst queue, the percentage
//   register and the result queue to out_item. Rate: one sample per cycle
//   while full is low; the front end updates the average as each sample is taken.
//   If pop stays low, the two-entry result queue and the two-entry burst queue
//   fill and full rises; samples that do not close a burst then wait too.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at once;
//   unknown indexes are ignored. Write only while the block is idle.
//   Reset (rst_n low, synchronous) restores register defaults, empties both
//   queues, clears the band counters and sets the confirmed band to good.
// ----------------------------------------------------------------------------
module battery_level_supervisor import bls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               in_item,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [OFFSET_BITS-1:0] cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  meas_q_t meas_q;
  logic    meas_pop;

  // configuration register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHECKING_ENABLE: cfg_nxt.checking_enable = cfg_wdata[0];
        CFG_ADC_OFFSET:      cfg_nxt.adc_offset      = cfg_wdata;
        CFG_GOOD_LEVEL:      cfg_nxt.good_level      = cfg_wdata[7:0];
        CFG_CRITICAL_LEVEL:  cfg_nxt.critical_level  = cfg_wdata[7:0];
        CFG_CONFIRM_COUNT:   cfg_nxt.confirm_count   = cfg_wdata[3:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.checking_enable <= 1'b1;
      cfg_r.adc_offset      <= OFFSET_BITS'(1650);
      cfg_r.good_level      <= 8'd50;
      cfg_r.critical_level  <= 8'd10;
      cfg_r.confirm_count   <= 4'd15;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sample averaging front end
  bls_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .checking_enable (cfg_r.checking_enable),
    .push            (push),
    .full            (full),
    .in_item         (in_item),
    .meas_q          (meas_q),
    .meas_pop        (meas_pop)
  );

  // percentage and band back end
  bls_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .meas_q   (meas_q),
    .meas_pop (meas_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// ===== rtl/bls_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_front
// Accepts samples, keeps the running halving average of a burst and queues
// the finished average of each burst for the back end.
// ----------------------------------------------------------------------------
module bls_front import bls_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     checking_enable,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output meas_q_t  meas_q,
  input  logic     meas_pop
);

  logic [ADC_BITS-1:0] avg_r, avg_nxt;
  logic                burst_start_r, burst_start_nxt;
  logic [ADC_BITS:0]   sum;
  logic                accept;
  logic                q_push;
  meas_t               q_mem_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          count_r, count_nxt;

  assign full   = (count_r == 2'd2);
  assign accept = push && !full;

  // running average update
  always_comb begin
    sum             = {1'b0, avg_r} + {1'b0, in_item.adc_sample};
    avg_nxt         = avg_r;
    burst_start_nxt = burst_start_r;
    q_push          = 1'b0;
    if (accept && checking_enable) begin
      avg_nxt         = burst_start_r ? in_item.adc_sample : sum[ADC_BITS:1];
      burst_start_nxt = in_item.last_sample;
      q_push          = in_item.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r         <= '0;
      burst_start_r <= 1'b1;
    end else begin
      avg_r         <= avg_nxt;
      burst_start_r <= burst_start_nxt;
    end
  end

  // two-entry queue toward the back end
  always_comb begin
    count_nxt = count_r;
    if (q_push && !meas_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!q_push && meas_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (q_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (meas_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[wr_ptr_r] <= '{average: avg_nxt, mode: in_item.system_mode};
    end
  end

  assign meas_q.valid = (count_r != 2'd0);
  assign meas_q.meas  = q_mem_r[rd_ptr_r];

endmodule

// ===== rtl/bls_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_back
// Turns a burst average into a percentage, sorts it into a band, confirms
// bands with per-band counters and queues the result transactions.
// ----------------------------------------------------------------------------
module bls_back import bls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  meas_q_t   meas_q,
  output logic      meas_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  diff;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [7:0]        pct;

  logic              pct_v_r, pct_v_nxt;
  logic [7:0]        pct_r;
  logic [2:0]        mode_r;

  logic [3:0]        good_cnt_r, good_cnt_nxt;
  logic [3:0]        med_cnt_r, med_cnt_nxt;
  logic [3:0]        crit_cnt_r, crit_cnt_nxt;
  logic [1:0]        band_r, band_nxt;
  logic [3:0]        bumped;
  logic [2:0]        mode_out;

  logic              out_full;
  logic              out_push;
  out_item_t         q_mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r, count_nxt;

  assign out_full = (count_r == 2'd2);
  assign out_push = pct_v_r && !out_full;
  assign meas_pop = meas_q.valid && (!pct_v_r || out_push);

  // clamp, remove offset, divide by ten by reciprocal multiply, saturate
  always_comb begin
    level = LVL_W'(meas_q.meas.average);
    if (level < LVL_W'(cfg.adc_offset)) begin
      level = LVL_W'(cfg.adc_offset);
    end
    diff = level - LVL_W'(cfg.adc_offset);
    prod = PROD_W'(diff) * PROD_W'(DIV10_MULT);
    quot = prod[PROD_W-1:DIV10_SHIFT];
    if (quot > QUOT_W'(PERCENT_MAX)) begin
      pct = PERCENT_MAX;
    end else begin
      pct = quot[7:0];
    end
  end

  // percentage stage
  always_comb begin
    pct_v_nxt = pct_v_r;
    if (meas_pop) begin
      pct_v_nxt = 1'b1;
    end else if (out_push) begin
      pct_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_v_r <= 1'b0;
    end else begin
      pct_v_r <= pct_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (meas_pop) begin
      pct_r  <= pct;
      mode_r <= meas_q.meas.mode;
    end
  end

  // band classification and confirmation counters
  always_comb begin
    good_cnt_nxt = good_cnt_r;
    med_cnt_nxt  = med_cnt_r;
    crit_cnt_nxt = crit_cnt_r;
    band_nxt     = band_r;
    mode_out     = mode_r;
    bumped       = '0;
    if (pct_r > cfg.good_level) begin
      bumped       = (good_cnt_r < COUNT_MAX) ? good_cnt_r + 4'd1 : good_cnt_r;
      good_cnt_nxt = bumped;
      if (bumped >= cfg.confirm_count) begin
        if (mode_r == MODE_LOW) begin
          mode_out = MODE_RUN;
        end
        band_nxt     = BAND_GOOD;
        good_cnt_nxt = '0;
        med_cnt_nxt  = '0;
        crit_cnt_nxt = '0;
      end
    end else if (pct_r > cfg.critical_level) begin
      bumped      = (med_cnt_r < COUNT_MAX) ? med_cnt_r + 4'd1 : med_cnt_r;
      med_cnt_nxt = bumped;
      if (bumped >= cfg.confirm_count) begin
        if (mode_r == MODE_RUN) begin
          mode_out = MODE_LOW;
        end
        band_nxt     = BAND_MEDIUM;
        good_cnt_nxt = '0;
        med_cnt_nxt  = '0;
        crit_cnt_nxt = '0;
      end
    end else begin
      bumped       = (crit_cnt_r < COUNT_MAX) ? crit_cnt_r + 4'd1 : crit_cnt_r;
      crit_cnt_nxt = bumped;
      if (bumped >= cfg.confirm_count) begin
        mode_out     = MODE_DISABLED;
        band_nxt     = BAND_CRITICAL;
        good_cnt_nxt = '0;
        med_cnt_nxt  = '0;
        crit_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_cnt_r <= '0;
      med_cnt_r  <= '0;
      crit_cnt_r <= '0;
      band_r     <= BAND_GOOD;
    end else if (out_push) begin
      good_cnt_r <= good_cnt_nxt;
      med_cnt_r  <= med_cnt_nxt;
      crit_cnt_r <= crit_cnt_nxt;
      band_r     <= band_nxt;
    end
  end

  // two-entry result queue
  always_comb begin
    count_nxt = count_r;
    if (out_push && !(pop && !empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!out_push && pop && !empty) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (out_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      q_mem_r[wr_ptr_r] <= '{battery_percent: pct_r,
                             battery_band:    band_nxt,
                             next_mode:       mode_out};
    end
  end

  assign empty    = (count_r == 2'd0);
  assign out_item = q_mem_r[rd_ptr_r];

endmodule
